// ===== hdl/rau_pkg.sv =====
package rau_pkg;

   localparam int WORD_BITS_DEFAULT = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_RED = 3'd4;
   localparam logic [2:0] OP_EQ  = 3'd5;
   localparam logic [2:0] OP_NE  = 3'd6;
   localparam logic [2:0] OP_LT  = 3'd7;

   // bundle of classified work handed from front to back
   typedef struct packed {
      logic is_cmp;
      logic truth;
      logic negative;
   } job_ctl_type;

endpackage

// ===== hdl/rau_front.sv =====
// front: forms cross products in turn and classifies the item
module rau_front
   import rau_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [2:0]           operation,
   input  logic                 a_negative,
   input  logic [WORD_BITS-1:0] a_numerator,
   input  logic [WORD_BITS-1:0] a_denominator,
   input  logic                 b_negative,
   input  logic [WORD_BITS-1:0] b_numerator,
   input  logic [WORD_BITS-1:0] b_denominator,
   output logic                 out_valid,
   input  logic                 out_ready,
   output job_ctl_type          out_ctl,
   output logic [WORD_BITS-1:0] out_num,
   output logic [WORD_BITS-1:0] out_den
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [1:0]           step_ff, step_in;
   logic [2:0]           op_ff, op_in;
   logic                 an_ff, an_in, bn_ff, bn_in;
   logic [WORD_BITS-1:0] anum_ff, anum_in, aden_ff, aden_in;
   logic [WORD_BITS-1:0] bnum_ff, bnum_in, bden_ff, bden_in;
   logic [WORD_BITS-1:0] p_ff, p_in, q_ff, q_in, r_ff, r_in;
   job_ctl_type          ctl_ff, ctl_in;
   logic [WORD_BITS-1:0] num_ff, num_in, den_ff, den_in;
   logic [WORD_BITS-1:0] mul_x, mul_y, mul_z;
   logic                 sb, p_gt;

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_OUT);
   assign out_ctl   = ctl_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;

   // one shared multiplier, one product per cycle
   always_comb begin
      mul_x = anum_ff;
      mul_y = bden_ff;
      case (step_ff)
         2'd0: begin mul_x = anum_ff; mul_y = bden_ff; end
         2'd1: begin mul_x = bnum_ff; mul_y = aden_ff; end
         2'd2: begin
            mul_x = aden_ff;
            mul_y = (op_ff == OP_DIV) ? bnum_ff : bden_ff;
         end
         default: begin mul_x = anum_ff; mul_y = bnum_ff; end
      endcase
      mul_z = mul_x * mul_y;
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      op_in = op_ff; an_in = an_ff; bn_in = bn_ff;
      anum_in = anum_ff; aden_in = aden_ff; bnum_in = bnum_ff; bden_in = bden_ff;
      p_in = p_ff; q_in = q_ff; r_in = r_ff;
      ctl_in = ctl_ff; num_in = num_ff; den_in = den_ff;
      sb   = (op_ff == OP_SUB) ? ~bn_ff : bn_ff;
      p_gt = p_ff > q_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               op_in = operation; an_in = a_negative; bn_in = b_negative;
               anum_in = a_numerator; aden_in = a_denominator;
               bnum_in = b_numerator; bden_in = b_denominator;
               step_in = 2'd0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            case (step_ff)
               2'd0: p_in = mul_z;
               2'd1: q_in = mul_z;
               2'd2: r_in = mul_z;
               default: p_in = mul_z;
            endcase
            step_in = step_ff + 2'd1;
            // multiply takes a fourth product for the numerator
            if (step_ff == 2'd3 || (step_ff == 2'd2 && op_ff != OP_MUL)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            ctl_in = '0;
            num_in = '0;
            den_in = r_ff;
            case (op_ff)
               OP_ADD, OP_SUB: begin
                  if (an_ff == sb) begin
                     ctl_in.negative = an_ff;
                     num_in = p_ff + q_ff;
                  end else begin
                     num_in = p_gt ? (p_ff - q_ff) : (q_ff - p_ff);
                     ctl_in.negative = an_ff ? p_gt : ~p_gt;
                  end
               end
               OP_MUL, OP_DIV: begin
                  ctl_in.negative = an_ff ^ bn_ff;
                  num_in = p_ff;
               end
               OP_RED: begin
                  ctl_in.negative = an_ff;
                  num_in = anum_ff;
                  den_in = aden_ff;
               end
               OP_EQ, OP_NE: begin
                  ctl_in.is_cmp = 1'b1;
                  den_in = '0;
                  ctl_in.truth = ((an_ff == bn_ff) && (anum_ff == bnum_ff)
                                  && (aden_ff == bden_ff)) ^ (op_ff == OP_NE);
               end
               default: begin
                  ctl_in.is_cmp = 1'b1;
                  den_in = '0;
                  if (an_ff != bn_ff) ctl_in.truth = an_ff;
                  else if (an_ff) ctl_in.truth = p_gt;
                  else ctl_in.truth = p_ff < q_ff;
               end
            endcase
            state_in = ST_OUT;
         end
         default: begin
            if (out_ready) state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      op_ff <= op_in; an_ff <= an_in; bn_ff <= bn_in;
      anum_ff <= anum_in; aden_ff <= aden_in; bnum_ff <= bnum_in; bden_ff <= bden_in;
      p_ff <= p_in; q_ff <= q_in; r_ff <= r_in;
      ctl_ff <= ctl_in; num_ff <= num_in; den_ff <= den_in;
   end

endmodule

// ===== hdl/rau_queue.sv =====
// short fifo between front and back
module rau_queue
   import rau_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  job_ctl_type          in_ctl,
   input  logic [WORD_BITS-1:0] in_num,
   input  logic [WORD_BITS-1:0] in_den,
   output logic                 out_valid,
   input  logic                 out_ready,
   output job_ctl_type          out_ctl,
   output logic [WORD_BITS-1:0] out_num,
   output logic [WORD_BITS-1:0] out_den
);

   localparam int EW = $bits(job_ctl_type) + 2 * WORD_BITS;

   logic [EW-1:0] mem_ff [QUEUE_DEPTH];
   logic          wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          push, pop;

   assign in_ready  = (cnt_ff != 2'(QUEUE_DEPTH));
   assign out_valid = (cnt_ff != 2'd0);
   assign push = in_valid & in_ready;
   assign pop  = out_valid & out_ready;
   assign {out_ctl, out_num, out_den} = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= {in_ctl, in_num, in_den};
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(QUEUE_DEPTH)) else $error("queue count overflow");
   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> rp_ff != $past(rp_ff)) else $error("read pointer stuck");
   a_empty_when_zero: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !out_valid) else $error("valid while empty");

endmodule

// ===== hdl/rau_back.sv =====
// back: euclid gcd by restoring remainder, then two quotient divisions
module rau_back
   import rau_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  job_ctl_type          in_ctl,
   input  logic [WORD_BITS-1:0] in_num,
   input  logic [WORD_BITS-1:0] in_den,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic                 res_negative,
   output logic [WORD_BITS-1:0] res_numerator,
   output logic [WORD_BITS-1:0] res_denominator,
   output logic                 truth,
   output logic                 fault
);

   localparam int CW = $clog2(WORD_BITS + 1);
   localparam int IW = $clog2(WORD_BITS);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_GCD  = 3'd1;
   localparam logic [2:0] ST_QN   = 3'd2;
   localparam logic [2:0] ST_QD   = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0]           state_ff, state_in;
   job_ctl_type          ctl_ff, ctl_in;
   logic [WORD_BITS-1:0] num_ff, num_in, den_ff, den_in;
   logic [WORD_BITS-1:0] x_ff, x_in, y_ff, y_in;
   logic [WORD_BITS-1:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [CW-1:0]        bit_ff, bit_in;
   logic                 busy_ff, busy_in;
   logic [WORD_BITS:0]   trial;
   logic [WORD_BITS-1:0] dividend, divisor;
   logic [IW-1:0]        bit_idx;
   logic                 fit;

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_OUT);
   assign res_negative    = ctl_ff.negative;
   assign res_numerator   = num_ff;
   assign res_denominator = den_ff;
   assign truth = ctl_ff.truth;
   assign fault = ctl_ff.is_cmp ? 1'b0 : (x_ff == '0);

   // one restoring divide step per cycle, shared by gcd and quotients
   always_comb begin
      dividend = (state_ff == ST_GCD) ? x_ff : ((state_ff == ST_QN) ? num_ff : den_ff);
      divisor  = (state_ff == ST_GCD) ? y_ff : x_ff;
      bit_idx  = IW'(bit_ff - CW'(1));
      trial = {rem_ff, dividend[bit_idx]} - {1'b0, divisor};
      fit   = ~trial[WORD_BITS];
   end

   always_comb begin
      state_in = state_ff; ctl_in = ctl_ff; num_in = num_ff; den_in = den_ff;
      x_in = x_ff; y_in = y_ff; rem_in = rem_ff; quo_in = quo_ff;
      bit_in = bit_ff; busy_in = busy_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               ctl_in = in_ctl; num_in = in_num; den_in = in_den;
               x_in = in_num; y_in = in_den;
               busy_in = 1'b0;
               state_in = in_ctl.is_cmp ? ST_OUT : ST_GCD;
            end
         end
         ST_GCD: begin
            if (y_ff == '0) begin
               if (x_ff == '0) begin
                  num_in = '0; den_in = '0; ctl_in.negative = 1'b0;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_QN;
                  rem_in = '0; quo_in = '0; bit_in = CW'(WORD_BITS);
               end
            end else if (!busy_ff) begin
               busy_in = 1'b1; rem_in = '0; bit_in = CW'(WORD_BITS);
            end else begin
               rem_in = fit ? trial[WORD_BITS-1:0] : {rem_ff[WORD_BITS-2:0],
                        dividend[bit_idx]};
               bit_in = bit_ff - CW'(1);
               if (bit_ff == CW'(1)) begin
                  x_in = y_ff; y_in = rem_in; busy_in = 1'b0;
               end
            end
         end
         ST_QN, ST_QD: begin
            rem_in = fit ? trial[WORD_BITS-1:0] : {rem_ff[WORD_BITS-2:0],
                     dividend[bit_idx]};
            quo_in = {quo_ff[WORD_BITS-2:0], fit};
            bit_in = bit_ff - CW'(1);
            if (bit_ff == CW'(1)) begin
               rem_in = '0; bit_in = CW'(WORD_BITS);
               if (state_ff == ST_QN) begin
                  num_in = quo_in; state_in = ST_QD;
               end else begin
                  den_in = quo_in; state_in = ST_OUT;
               end
            end
         end
         default: begin
            if (out_ready) state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
      ctl_ff <= ctl_in; num_ff <= num_in; den_ff <= den_in;
      x_ff <= x_in; y_ff <= y_in; rem_ff <= rem_in; quo_ff <= quo_in;
      bit_ff <= bit_in;
   end

   a_cmp_no_fault: assert property (@(posedge clock) disable iff (reset)
      out_valid && ctl_ff.is_cmp |-> !fault && res_numerator == '0)
      else $error("comparison carries arithmetic result");
   a_arith_no_truth: assert property (@(posedge clock) disable iff (reset)
      out_valid && !ctl_ff.is_cmp |-> !truth) else $error("truth on arithmetic");
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid && fault |-> res_numerator == '0 && res_denominator == '0
      && !res_negative) else $error("fault with nonzero result");

endmodule

// ===== hdl/rational_arithmetic_unit.sv =====
// channel | dir | tdata fields (low bit first)                     | tuser
// req_    | in  | a_num, a_den, b_num, b_den                        | op, a_neg, b_neg
// rsp_    | out | res_numerator, res_denominator                    | neg, truth, fault
//
// front forms three cross products, four for multiply (shared multiplier, one product a cycle)
// back runs euclid with one remainder bit a cycle, then two quotient divisions by the
// gcd for numerator and denominator; comparisons skip euclid and the quotients
// synchronous active-high reset clears the state registers and queue pointers, queue empties
// each side stalls alone; the two-entry queue absorbs a stalled rsp_ side
module rational_arithmetic_unit
   import rau_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // a_numerator, a_denominator, b_numerator, b_denominator
   input  logic [4*WORD_BITS-1:0] req_tdata,
   // operation[2:0], a_negative, b_negative
   input  logic [4:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // res_numerator, res_denominator
   output logic [2*WORD_BITS-1:0] rsp_tdata,
   // res_negative, truth, fault
   output logic [2:0]             rsp_tuser
);

   logic                 f_valid, f_ready, q_valid, q_ready;
   job_ctl_type          f_ctl, q_ctl;
   logic [WORD_BITS-1:0] f_num, f_den, q_num, q_den, r_num, r_den;
   logic                 r_neg, r_truth, r_fault;

   rau_front #(.WORD_BITS(WORD_BITS)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .operation(req_tuser[2:0]), .a_negative(req_tuser[3]),
      .a_numerator(req_tdata[WORD_BITS-1:0]),
      .a_denominator(req_tdata[2*WORD_BITS-1:WORD_BITS]),
      .b_negative(req_tuser[4]),
      .b_numerator(req_tdata[3*WORD_BITS-1:2*WORD_BITS]),
      .b_denominator(req_tdata[4*WORD_BITS-1:3*WORD_BITS]),
      .out_valid(f_valid), .out_ready(f_ready),
      .out_ctl(f_ctl), .out_num(f_num), .out_den(f_den)
   );

   rau_queue #(.WORD_BITS(WORD_BITS)) u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready),
      .in_ctl(f_ctl), .in_num(f_num), .in_den(f_den),
      .out_valid(q_valid), .out_ready(q_ready),
      .out_ctl(q_ctl), .out_num(q_num), .out_den(q_den)
   );

   rau_back #(.WORD_BITS(WORD_BITS)) u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready),
      .in_ctl(q_ctl), .in_num(q_num), .in_den(q_den),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .res_negative(r_neg), .res_numerator(r_num), .res_denominator(r_den),
      .truth(r_truth), .fault(r_fault)
   );

   assign rsp_tdata = {r_den, r_num};
   assign rsp_tuser = {r_fault, r_truth, r_neg};

endmodule
